@@ rtl/ssort_pkg.sv @@
// Shared types and constants for the shell sort engine.
// No dependencies; imported by ssort_ram, ssort_seq and shell_sort_engine_top.
package ssort_pkg;

	// Width of one element word and default capacity of the element store
	localparam int VALUE_W   = 32;
	localparam int DEPTH_DEF = 16;

	// Sequencer states
	typedef enum logic [3:0] {
		S_LOAD,
		S_GAP,
		S_RD_HELD,
		S_HELD,
		S_CHK,
		S_CMP,
		S_NEXT,
		S_EMIT_RD,
		S_EMIT_WR
	} state_t;

	// Result load request from the sequencer to the output register
	typedef struct packed {
		logic load;
		logic last;
		logic ovf;
	} emit_t;

endpackage

@@ rtl/shell_sort_engine_top.sv @@
// Channel   Dir  Handshake           Word fields
// in        in   in_valid/in_ready   in_value[31:0] signed, in_last
// out       out  out_valid/out_ready out_value[31:0] signed, out_last, overflow
//
// Loading writes each accepted input word to the store. After the last word the store
// is sorted in place, gap by gap: each element is read and held, the word one gap back
// is shifted up while larger, and the held word is written where it settles, paced by
// the single read port. Readout reads each result, then loads the output register.
// Input is refused from the last input word until the final result is in the output
// register. Reset clears control only; no clearing pass. A stalled output holds readout.
//
// Top level of the shell sort engine: element store, sequencer, output register.
// Depends on ssort_pkg, ssort_ram and ssort_seq.
module shell_sort_engine_top import ssort_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [VALUE_W-1:0] in_value,
	input  logic                      in_last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VALUE_W-1:0] out_value,
	output logic                      out_last,
	output logic                      overflow
);

	localparam int AW = $clog2(DEPTH);

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [VALUE_W-1:0] wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [VALUE_W-1:0] rd_data;
	logic               out_free;
	emit_t              emit;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_last_q;
	logic               ovf_q;

	ssort_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ssort_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_value (in_value),
		.in_last  (in_last),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.out_free (out_free),
		.emit     (emit)
	);

	// Output register: free when empty or being taken this cycle
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.load) begin
			out_value_q <= rd_data;
			out_last_q  <= emit.last;
			ovf_q       <= emit.ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign overflow  = ovf_q;

	// A result word is only loaded into an empty output register
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		emit.load |-> !out_valid_q)
		else $error("result loaded over a pending output word");

	// The store is never read and written at the same entry in one cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_en && wr_en) |-> (rd_addr != wr_addr))
		else $error("store read and write collide");

	// After the final result is loaded, the next set can be taken
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.load && emit.last) |=> in_ready)
		else $error("input not reopened after final result");

endmodule

@@ rtl/ssort_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on ssort_pkg for default parameter values.
module ssort_ram import ssort_pkg::*; #(
	parameter int WIDTH = VALUE_W,
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port; data holds when not reading
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ rtl/ssort_seq.sv @@
// Sequencer of the shell sort engine: load, gapped insertion passes, readout.
// Depends on ssort_pkg (state_t, emit_t, VALUE_W); drives the ports of one ssort_ram.
module ssort_seq import ssort_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// input words
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [VALUE_W-1:0]  in_value,
	input  logic                       in_last,
	// element store
	output logic                       wr_en,
	output logic [$clog2(DEPTH)-1:0]   wr_addr,
	output logic [VALUE_W-1:0]         wr_data,
	output logic                       rd_en,
	output logic [$clog2(DEPTH)-1:0]   rd_addr,
	input  logic [VALUE_W-1:0]         rd_data,
	// output register
	input  logic                       out_free,
	output emit_t                      emit
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);
	localparam logic [CW-1:0] ONE  = CW'(1);

	state_t            state_q, state_nx;
	logic [CW-1:0]     count_q;
	logic              drop_q;
	logic [CW-1:0]     gap_q;
	logic [CW-1:0]     i_q;
	logic [CW-1:0]     pos_q;
	logic [CW-1:0]     k_q;
	logic [VALUE_W-1:0] held_q;

	logic              store_ok;
	logic [CW-1:0]     n_next;
	logic [CW-1:0]     i_inc;
	logic [CW-1:0]     k_inc;
	logic [CW-1:0]     pos_dn;
	logic              pos_ge;
	logic              cmp_gt;
	logic              k_last;

	assign store_ok = count_q < FULL;
	assign n_next   = store_ok ? count_q + ONE : count_q;
	assign i_inc    = i_q + ONE;
	assign k_inc    = k_q + ONE;
	assign pos_dn   = pos_q - gap_q;
	assign pos_ge   = pos_q >= gap_q;
	assign cmp_gt   = $signed(rd_data) > $signed(held_q);
	assign k_last   = k_inc == count_q;

	// Next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_LOAD:    if (in_valid && in_last) state_nx = S_GAP;
			S_GAP:     state_nx = (gap_q == '0) ? S_EMIT_RD : S_RD_HELD;
			S_RD_HELD: state_nx = S_HELD;
			S_HELD:    state_nx = S_CHK;
			S_CHK:     state_nx = pos_ge ? S_CMP : S_NEXT;
			S_CMP:     state_nx = cmp_gt ? S_CHK : S_NEXT;
			S_NEXT:    state_nx = (i_inc == count_q) ? S_GAP : S_RD_HELD;
			S_EMIT_RD: if (out_free) state_nx = S_EMIT_WR;
			S_EMIT_WR: state_nx = k_last ? S_LOAD : S_EMIT_RD;
			default:   state_nx = S_LOAD;
		endcase
	end

	// Store accesses, handshake and result loads per state
	always_comb begin
		in_ready  = 1'b0;
		wr_en     = 1'b0;
		wr_addr   = pos_q[AW-1:0];
		wr_data   = held_q;
		rd_en     = 1'b0;
		rd_addr   = i_q[AW-1:0];
		emit.load = 1'b0;
		emit.last = k_last;
		emit.ovf  = drop_q;
		case (state_q)
			S_LOAD: begin
				in_ready = 1'b1;
				wr_en    = in_valid && store_ok;
				wr_addr  = count_q[AW-1:0];
				wr_data  = in_value;
			end
			S_RD_HELD: begin
				rd_en = 1'b1;
			end
			S_CHK: begin
				// look one gap back, or drop the held word in place
				if (pos_ge) begin
					rd_en   = 1'b1;
					rd_addr = pos_dn[AW-1:0];
				end else begin
					wr_en = 1'b1;
				end
			end
			S_CMP: begin
				// shift the larger word up, or settle the held word here
				wr_en   = 1'b1;
				wr_data = cmp_gt ? rd_data : held_q;
			end
			S_EMIT_RD: begin
				rd_en   = out_free;
				rd_addr = k_q[AW-1:0];
			end
			S_EMIT_WR: begin
				emit.load = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			count_q <= '0;
			drop_q  <= 1'b0;
			gap_q   <= '0;
			i_q     <= '0;
			pos_q   <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				S_LOAD: begin
					if (in_valid) begin
						count_q <= n_next;
						if (!store_ok) drop_q <= 1'b1;
						if (in_last) gap_q <= n_next >> 1;
					end
				end
				S_GAP: begin
					i_q <= gap_q;
					k_q <= '0;
				end
				S_HELD: begin
					pos_q <= i_q;
				end
				S_CMP: begin
					if (cmp_gt) pos_q <= pos_dn;
				end
				S_NEXT: begin
					i_q <= i_inc;
					if (i_inc == count_q) gap_q <= gap_q >> 1;
				end
				S_EMIT_WR: begin
					k_q <= k_inc;
					if (k_last) begin
						count_q <= '0;
						drop_q  <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Held word of the current insertion
	always_ff @(posedge clk) begin
		if (state_q == S_HELD) begin
			held_q <= rd_data;
		end
	end

endmodule

@@ verif/tb_shell_sort_engine_top.sv @@
// Self-checking testbench for shell_sort_engine_top: loads sets of signed words,
// predicts the sorted readout and overflow marking, and checks every output word.
// Depends on ssort_pkg and the shell_sort_engine_top RTL.
module tb_shell_sort_engine_top import ssort_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH      = DEPTH_DEF;
	localparam int PHASES     = 4;
	localparam int PHASE_WORDS = 101;

	typedef logic signed [VALUE_W-1:0] value_t;

	typedef struct {
		value_t value;
		logic   last;
	} in_word_t;

	typedef struct {
		value_t value;
		logic   last;
		logic   ovf;
	} out_word_t;

	// Clock, reset and DUT ports
	logic   clk       = 1'b0;
	logic   arst_n    = 1'b0;
	logic   in_valid  = 1'b0;
	logic   in_ready;
	value_t in_value  = '0;
	logic   in_last   = 1'b0;
	logic   out_valid;
	logic   out_ready = 1'b0;
	value_t out_value;
	logic   out_last;
	logic   overflow;

	always #5 clk = ~clk;

	shell_sort_engine_top #(.DEPTH(DEPTH)) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_value (in_value),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_value(out_value),
		.out_last (out_last),
		.overflow (overflow)
	);

	// Queues: words waiting to be sent, sorted words waiting to come out
	in_word_t  in_words_q[$];
	out_word_t sorted_q[$];

	// Mirror of the engine state
	value_t      set_store[DEPTH];
	int unsigned set_count   = 0;
	logic        set_dropped = 1'b0;

	int   snd_idle_pct = 0;
	int   rcv_stall_pct = 0;
	bit   in_fire = 1'b0;
	int   err_count = 0;
	int   words_in = 0;
	int   words_out = 0;
	int   sets_done = 0;
	int   ovf_sets = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		err_count++;
	endtask

	// Gapped insertion sort, gap halving from n/2 down to 1
	function automatic void shell_sort_set(input int n);
		int     gap;
		int     i;
		int     pos;
		value_t held;
		gap = n / 2;
		while (gap > 0) begin
			for (i = gap; i < n; i++) begin
				held = set_store[i];
				pos  = i;
				while (pos >= gap && set_store[pos - gap] > held) begin
					set_store[pos] = set_store[pos - gap];
					pos -= gap;
				end
				set_store[pos] = held;
			end
			gap = gap / 2;
		end
	endfunction

	// Store one accepted word; on the closing word, queue the sorted set
	task automatic take_in_word(input value_t v, input logic l);
		out_word_t w;
		int        k;
		words_in++;
		if (set_count < DEPTH) begin
			set_store[set_count] = v;
			set_count++;
		end else begin
			set_dropped = 1'b1;
		end
		if (l) begin
			shell_sort_set(set_count);
			for (k = 0; k < set_count; k++) begin
				w.value = set_store[k];
				w.last  = (k + 1 == set_count);
				w.ovf   = set_dropped;
				sorted_q.push_back(w);
			end
			sets_done++;
			if (set_dropped)
				ovf_sets++;
			set_count   = 0;
			set_dropped = 1'b0;
		end
	endtask

	// Input sampling and output checking at the rising edge
	always @(posedge clk) begin
		out_word_t e;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				in_fire = 1'b1;
				take_in_word(in_value, in_last);
			end
			if (out_valid && out_ready) begin
				words_out++;
				if (sorted_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word value=%0d last=%0b ovf=%0b",
						out_value, out_last, overflow));
				end else begin
					e = sorted_q.pop_front();
					if (out_value !== e.value)
						report_mismatch($sformatf("value got %0d exp %0d", out_value, e.value));
					if (out_last !== e.last)
						report_mismatch($sformatf("last got %b exp %b", out_last, e.last));
					if (overflow !== e.ovf)
						report_mismatch($sformatf("overflow got %b exp %b", overflow, e.ovf));
				end
			end
		end
	end

	// Input driver: holds the word until accepted, then maybe idles
	always @(negedge clk) begin
		in_word_t w;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_fire) begin
			in_fire = 1'b0;
			if (in_words_q.size() == 0 || $urandom_range(99) < snd_idle_pct) begin
				in_valid <= 1'b0;
			end else begin
				w = in_words_q.pop_front();
				in_valid <= 1'b1;
				in_value <= w.value;
				in_last  <= w.last;
			end
		end
	end

	// Output back-pressure
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rcv_stall_pct);
	end

	task automatic queue_word(input value_t v, input logic l);
		in_word_t w;
		w.value = v;
		w.last  = l;
		in_words_q.push_back(w);
	endtask

	// Full range, a few small values (duplicates), or extremes mixed in
	function automatic value_t rand_value(input int mode);
		case (mode)
			0: rand_value = $signed($urandom);
			1: rand_value = $signed($urandom_range(6)) - 3;
			default: begin
				case ($urandom_range(4))
					0: rand_value = 32'sh7fff_ffff;
					1: rand_value = 32'sh8000_0000;
					2: rand_value = 0;
					3: rand_value = -1;
					default: rand_value = $signed($urandom);
				endcase
			end
		endcase
	endfunction

	// One well-formed set of n words with random content
	task automatic queue_set(input int n);
		int mode;
		int k;
		mode = $urandom_range(2);
		for (k = 0; k < n; k++)
			queue_word(rand_value(mode), k == n - 1);
	endtask

	// Random set size: mostly within capacity, some full, some overflowing
	function automatic int rand_set_size();
		int r;
		r = $urandom_range(99);
		if (r < 15)
			rand_set_size = $urandom_range(DEPTH + 4, DEPTH + 1);
		else if (r < 35)
			rand_set_size = DEPTH;
		else if (r < 45)
			rand_set_size = $urandom_range(2, 1);
		else
			rand_set_size = $urandom_range(DEPTH - 1, 1);
	endfunction

	// Stimulus: reset, directed sets, then random sets over the idling phases
	initial begin
		int snd_tab[PHASES];
		int rcv_tab[PHASES];
		int ph;
		int k;
		int n;
		int phase_words;
		snd_tab = '{0, 61, 0, 7};
		rcv_tab = '{0, 0, 61, 7};
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed: two equal words
		queue_word(-1, 1'b0);
		queue_word(-1, 1'b1);
		// Directed: extremes and alternating bit patterns
		queue_word(32'sh7fff_ffff, 1'b0);
		queue_word(32'sh8000_0000, 1'b0);
		queue_word(0, 1'b0);
		queue_word(32'sh5555_5555, 1'b0);
		queue_word(32'shaaaa_aaaa, 1'b0);
		queue_word(1, 1'b1);
		// Directed: reverse order past capacity, closing word is dropped
		for (k = 0; k < DEPTH + 2; k++)
			queue_word((9 - k) * 1000003, k == DEPTH + 1);

		for (ph = 0; ph < PHASES; ph++) begin
			snd_idle_pct  = snd_tab[ph];
			rcv_stall_pct = rcv_tab[ph];
			phase_words = 0;
			while (phase_words < PHASE_WORDS) begin
				n = rand_set_size();
				queue_set(n);
				phase_words += n;
			end
			// Sender pauses until all sorted words of the phase are out
			while (in_words_q.size() != 0 || in_valid || sorted_q.size() != 0)
				@(negedge clk);
			repeat (10) @(negedge clk);
			@(posedge clk);
		end

		repeat (20) @(posedge clk);
		$display("run covered %0d sets (%0d with dropped words)", sets_done, ovf_sets);
		$display("%0d words sent, %0d sorted words checked", words_in, words_out);
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#(10_000_000);
		$display("timeout with %0d sorted words outstanding", sorted_q.size());
		$display("status: fail");
		$finish;
	end

endmodule
